// File: sv/htpr_pkg.sv
// Package with the constants, widths and helper functions of the hash-to-point sampler.
package htpr_pkg;

  // Default sizes of the block.
  localparam int DEF_MAX_LOG_DEGREE = 9;
  localparam int DEF_STORE_DEPTH    = 1024;

  // Width of set sizes and positions before they are cut to the store.
  localparam int SZ_W   = 12;
  // Width of the pass stride, which runs up to twice the largest oversampling count.
  localparam int P_W    = 10;
  // Width of an oversampling count.
  localparam int OVER_W = 9;

  // Modulus and its multiples used by the reduction.
  localparam logic [15:0] Q_MOD        = 16'd12289;
  localparam logic [15:0] Q_TWICE      = 16'd24578;
  localparam logic [15:0] Q_THRICE     = 16'd36867;
  localparam logic [15:0] Q_FOUR       = 16'd49156;
  localparam logic [15:0] REJECT_BOUND = 16'd61445;
  localparam logic [15:0] INVALID_WORD = 16'hFFFF;

  // Request codes.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Extra words drawn beyond n for each log degree.
  function automatic logic [OVER_W-1:0] over_count(input logic [3:0] lg);
    logic [OVER_W-1:0] res;
    case (lg)
      4'd1:    res = 9'd65;
      4'd2:    res = 9'd67;
      4'd3:    res = 9'd71;
      4'd4:    res = 9'd77;
      4'd5:    res = 9'd86;
      4'd6:    res = 9'd100;
      4'd7:    res = 9'd122;
      4'd8:    res = 9'd154;
      4'd9:    res = 9'd205;
      4'd10:   res = 9'd287;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // Rejects words at or above five times q, else reduces mod q with one subtraction
  // chosen by parallel compares.
  function automatic logic [15:0] reduce_word(input logic [15:0] w);
    logic [15:0] sub;
    if (w >= Q_FOUR) begin
      sub = Q_FOUR;
    end else if (w >= Q_THRICE) begin
      sub = Q_THRICE;
    end else if (w >= Q_TWICE) begin
      sub = Q_TWICE;
    end else if (w >= Q_MOD) begin
      sub = Q_MOD;
    end else begin
      sub = 16'd0;
    end
    if (w >= REJECT_BOUND) begin
      return INVALID_WORD;
    end
    return w - sub;
  endfunction

endpackage

// File: sv/hash_to_point_rejection_compact.sv
// Hash-to-point sampler: word reduction, sample store and in-place order-keeping compaction.
// Load: accepted and then strobed in the next cycle; busy stays low.
// Read: busy for one cycle of store read, then its word is strobed in the following cycle.
// Final load of a set: busy for passes of stride p = 1, 2, 4 and on up to the oversampling
//   count (S_EVAL per entry, S_WB per swap), then strobed; results cannot be held off.
// Reset clears the load count and the ready flag and sets log_degree to 9, but not the store.
module hash_to_point_rejection_compact
  import htpr_pkg::*;
#(
  parameter int MAX_LOG_DEGREE = DEF_MAX_LOG_DEGREE,
  parameter int STORE_DEPTH    = DEF_STORE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [15:0] sample,
  input  logic [8:0]  index,
  output logic        res_valid,
  output logic [15:0] coeff,
  output logic        ready_res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;

  // Control and configuration registers.
  logic [2:0]        state;
  logic [3:0]        log_degree;
  logic [CNT_W-1:0]  load_count;
  logic              done;
  logic              rd_ok;
  logic [15:0]       last_coeff;

  // Compaction sequencer registers.
  logic [CNT_W-1:0]  u;
  logic [CNT_W-1:0]  dest;
  logic [P_W-1:0]    p;
  logic [CNT_W-1:0]  m_c;
  logic [OVER_W-1:0] over_c;

  // Sample store and its port.
  logic [15:0]       store_mem [STORE_DEPTH];
  logic [15:0]       rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [15:0]       mem_wdata;
  logic [AW-1:0]     mem_raddr;

  // Derived values.
  logic [3:0]        eff_lg;
  logic [SZ_W-1:0]   n_sz;
  logic [SZ_W-1:0]   m_raw;
  logic [SZ_W-1:0]   m_sz;
  logic [OVER_W-1:0] over_cur;
  logic [15:0]       red;
  logic [CNT_W-1:0]  cnt_base;
  logic              can_store;
  logic [CNT_W-1:0]  cnt_next;
  logic              trigger;
  logic              accept;
  logic [SZ_W-1:0]   idx_sz;
  logic              idx_ok;
  logic [SZ_W-1:0]   u_sz;
  logic [SZ_W-1:0]   p_sz;
  logic [SZ_W-1:0]   jump;
  logic [SZ_W-1:0]   u_minus_p;
  logic              sv_valid;
  logic              swap;
  logic              last_u;
  logic [P_W-1:0]    p_next;
  logic              finish;
  logic [CNT_W-1:0]  u_inc;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Register clamping and set size for the current log degree.
  always_comb begin
    if (log_degree == 4'd0) begin
      eff_lg = 4'd1;
    end else if (log_degree > 4'(MAX_LOG_DEGREE)) begin
      eff_lg = 4'(MAX_LOG_DEGREE);
    end else begin
      eff_lg = log_degree;
    end
    over_cur = over_count(eff_lg);
    n_sz     = SZ_W'(1) << eff_lg;
    m_raw    = n_sz + SZ_W'(over_cur);
    m_sz     = (m_raw > SZ_W'(STORE_DEPTH)) ? SZ_W'(STORE_DEPTH) : m_raw;
  end

  // Load path: reduction, store slot and compaction trigger.
  always_comb begin
    red       = reduce_word(sample);
    cnt_base  = done ? '0 : load_count;
    can_store = (SZ_W'(cnt_base) < SZ_W'(STORE_DEPTH));
    cnt_next  = can_store ? cnt_base + CNT_W'(1) : cnt_base;
    trigger   = (SZ_W'(cnt_next) >= m_sz);
    idx_sz    = SZ_W'(index);
    idx_ok    = done && (idx_sz < n_sz) && (idx_sz < SZ_W'(load_count))
                && (idx_sz < SZ_W'(STORE_DEPTH));
  end

  // One compaction step on the entry that the store just returned.
  always_comb begin
    u_sz      = SZ_W'(u);
    p_sz      = SZ_W'(p);
    jump      = u_sz - SZ_W'(dest);
    u_minus_p = u_sz - p_sz;
    sv_valid  = !rdata[15];
    swap      = sv_valid && (u_sz >= p_sz) && ((jump & p_sz) != '0);
    last_u    = (u_sz == SZ_W'(m_c) - SZ_W'(1));
    p_next    = p << 1;
    finish    = (p_next > P_W'(over_c));
    u_inc     = u + CNT_W'(1);
  end

  // Store port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_base[AW-1:0];
    mem_wdata = red;
    mem_raddr = '0;
    case (state)
      S_IDLE: begin
        if (accept && req_type == REQ_LOAD) begin
          mem_we = can_store;
        end
        mem_raddr = idx_sz[AW-1:0];
      end
      S_EVAL: begin
        if (swap) begin
          mem_we    = 1'b1;
          mem_waddr = u_minus_p[AW-1:0];
          mem_wdata = rdata;
          mem_raddr = u_minus_p[AW-1:0];
        end else if (!last_u) begin
          mem_raddr = u_inc[AW-1:0];
        end
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = u[AW-1:0];
        mem_wdata = rdata;
        if (!last_u) begin
          mem_raddr = u_inc[AW-1:0];
        end
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  // Sample store.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rdata <= store_mem[mem_raddr];
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && req_type == REQ_LOAD) begin
      last_coeff <= red;
      m_c        <= CNT_W'(m_sz);
      over_c     <= over_cur;
    end
    if (state == S_IDLE && accept) begin
      rd_ok <= idx_ok;
    end
  end

  // Sequencer and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      log_degree <= 4'd9;
      load_count <= '0;
      done       <= 1'b0;
      res_valid  <= 1'b0;
      coeff      <= '0;
      ready_res  <= 1'b0;
      u          <= '0;
      dest       <= '0;
      p          <= '0;
    end else begin
      res_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        log_degree <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req_type == REQ_LOAD) begin
              load_count <= cnt_next;
              done       <= 1'b0;
              if (trigger) begin
                state <= S_START;
                p     <= P_W'(1);
              end else begin
                res_valid <= 1'b1;
                coeff     <= red;
                ready_res <= 1'b0;
              end
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          res_valid <= 1'b1;
          coeff     <= rd_ok ? rdata : INVALID_WORD;
          ready_res <= done;
          state     <= S_IDLE;
        end
        S_START: begin
          u     <= '0;
          dest  <= '0;
          state <= S_EVAL;
        end
        S_EVAL, S_WB: begin
          if (state == S_EVAL) begin
            dest <= sv_valid ? dest + CNT_W'(1) : dest;
          end
          if (state == S_EVAL && swap) begin
            state <= S_WB;
          end else if (!last_u) begin
            u     <= u_inc;
            state <= S_EVAL;
          end else if (finish) begin
            done      <= 1'b1;
            res_valid <= 1'b1;
            coeff     <= last_coeff;
            ready_res <= 1'b1;
            state     <= S_IDLE;
          end else begin
            p     <= p_next;
            u     <= '0;
            dest  <= '0;
            state <= S_EVAL;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A read keeps the block busy in the cycle after its start and then delivers its word.
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == REQ_READ |=> busy ##1 res_valid)
    else $error("read did not return its word two cycles after the start");

  // A word is never delivered while the block is busy.
  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !busy)
    else $error("result strobe while busy");

  // The ready flag stays low while compaction is running.
  a_done_low: assert property (@(posedge clk) disable iff (rst)
    (state == S_START || state == S_EVAL || state == S_WB) |-> !done)
    else $error("ready flag set during compaction");

  // The pass stride is a single power of two while a pass runs.
  a_stride: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL || state == S_WB) |-> $onehot(p))
    else $error("pass stride is not a power of two");

  // The ready flag rises only together with the final load's strobe.
  a_done_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> res_valid && ready_res)
    else $error("ready flag rose without a ready result");

endmodule
